[design/spq_pkg.sv]
// shared types and constants for the sorted priority queue
// no dependencies; imported by every module of the block

package spq_pkg;

  // defaults for the top-level parameters
  localparam int unsigned DEF_CAPACITY      = 16;
  localparam int unsigned DEF_PRIORITY_BITS = 16;

  // fixed field widths of the stream items
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 40;

  // opcodes carried by an input item
  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  // per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

[design/spq_cell.sv]
// one storage cell of the sorted chain: holds a single (priority, tag) entry
// depends on spq_pkg for the command struct

module spq_cell #(
  parameter int unsigned PW = 16
) (
  input  logic                      clk_i,
  input  spq_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      valid_i,
  input  logic                      prev_gt_i,
  input  logic [PW-1:0]             prev_prio_i,
  input  logic [spq_pkg::TAG_W-1:0] prev_tag_i,
  input  logic [PW-1:0]             next_prio_i,
  input  logic [spq_pkg::TAG_W-1:0] next_tag_i,
  input  logic [PW-1:0]             new_prio_i,
  input  logic [spq_pkg::TAG_W-1:0] new_tag_i,
  output logic                      gt_o,
  output logic [PW-1:0]             prio_o,
  output logic [spq_pkg::TAG_W-1:0] tag_o,
  output logic [PW-1:0]             prio_next_o,
  output logic [spq_pkg::TAG_W-1:0] tag_next_o
);
  import spq_pkg::*;

  logic [PW-1:0]    prio_q, prio_d;
  logic [TAG_W-1:0] tag_q, tag_d;

  // held entry outranks the new one strictly, so it stays closer to the top
  assign gt_o = valid_i && ($signed(prio_q) > $signed(new_prio_i));

  // keep, take the new entry, shift down from above, or shift up on remove
  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (ctrl_i.insert && !gt_o) begin
      if (prev_gt_i) begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end else begin
        prio_d = prev_prio_i;
        tag_d  = prev_tag_i;
      end
    end else if (ctrl_i.remove) begin
      prio_d = next_prio_i;
      tag_d  = next_tag_i;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o      = prio_q;
  assign tag_o       = tag_q;
  assign prio_next_o = prio_d;
  assign tag_next_o  = tag_d;

endmodule

[design/sorted_priority_queue_unit.sv]
// Sorted priority queue: a chain of CAPACITY cells kept in descending order, maximum in cell 0.
// An insert compares the new entry against all cells at once and shifts the lower
// part of the chain down by one cell, a remove shifts the whole chain up by one cell. A new item
// is accepted in every cycle in which the output register is empty or being drained, and its
// result appears in the output register on the following cycle. The capacity register may only
// be written while the queue is idle; 0 acts as 1 and values above CAPACITY act as CAPACITY.
// No clearing pass is needed after reset. Depends on spq_pkg and spq_cell.

module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY      = spq_pkg::DEF_CAPACITY,
  parameter int unsigned PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input items
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [1:0] opcode, [17:2] priority_in, [33:18] tag_in, [39:34] zero
  input  logic [spq_pkg::IN_W-1:0]  s_axis_tdata,
  // result items
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] ok, [16:1] top_priority, [32:17] top_tag, [37:33] count,
  // [38] is_empty, [39] is_full
  output logic [spq_pkg::OUT_W-1:0] m_axis_tdata,
  // capacity register write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [spq_pkg::CFG_W-1:0] cfg_data_i
);
  import spq_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned XW   = (PRIORITY_BITS > PRIO_W) ? PRIORITY_BITS : PRIO_W;

  logic [CFG_W-1:0]         cap_q;
  logic [CW-1:0]            count_q, count_d;
  logic [CMPW-1:0]          cap_raw, cap_eff;
  logic                     in_fire;
  opcode_e                  op;
  logic [XW-1:0]            in_prio_ext;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [TAG_W-1:0]         new_tag;
  logic                     can_insert, can_remove, ok;
  cell_ctrl_t               ctrl;

  logic [CAPACITY-1:0]      gt;
  logic [PRIORITY_BITS-1:0] prio_q  [CAPACITY];
  logic [TAG_W-1:0]         tag_q   [CAPACITY];
  logic [PRIORITY_BITS-1:0] prio_nx [CAPACITY];
  logic [TAG_W-1:0]         tag_nx  [CAPACITY];

  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_q;
  logic [XW-1:0]            top_ext;
  logic [PRIO_W-1:0]        top_prio;
  logic [TAG_W-1:0]         top_tag;
  logic                     empty_d, full_d;

  // capacity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CFG_W'(CAPACITY);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // effective capacity, saturated to 1..CAPACITY
  assign cap_raw = CMPW'(cap_q);
  always_comb begin
    cap_eff = cap_raw;
    if (cap_raw == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_raw > CMPW'(CAPACITY)) begin
      cap_eff = CMPW'(CAPACITY);
    end
  end

  // input decode
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = opcode_e'(s_axis_tdata[1:0]);
  assign in_prio_ext   = XW'(s_axis_tdata[17:2]);
  assign new_prio      = in_prio_ext[PRIORITY_BITS-1:0];
  assign new_tag       = s_axis_tdata[33:18];

  assign can_insert = (CMPW'(count_q) < cap_eff);
  assign can_remove = (count_q != '0);

  // operation and new count
  always_comb begin
    ok          = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.remove = 1'b0;
    count_d     = count_q;
    case (op)
      OP_INSERT: begin
        ok          = can_insert;
        ctrl.insert = in_fire && can_insert;
        if (can_insert) count_d = count_q + CW'(1);
      end
      OP_REMOVE: begin
        ok          = can_remove;
        ctrl.remove = in_fire && can_remove;
        if (can_remove) count_d = count_q - CW'(1);
      end
      OP_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire) begin
      count_q <= count_d;
    end
  end

  // cell chain
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                     prev_gt;
    logic [PRIORITY_BITS-1:0] prev_prio, next_prio;
    logic [TAG_W-1:0]         prev_tag, next_tag;

    if (k == 0) begin : g_head
      assign prev_gt   = 1'b1;
      assign prev_prio = '0;
      assign prev_tag  = '0;
    end else begin : g_body
      assign prev_gt   = gt[k-1];
      assign prev_prio = prio_q[k-1];
      assign prev_tag  = tag_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_prio = '0;
      assign next_tag  = '0;
    end else begin : g_mid
      assign next_prio = prio_q[k+1];
      assign next_tag  = tag_q[k+1];
    end

    spq_cell #(
      .PW (PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (count_q > CW'(k)),
      .prev_gt_i   (prev_gt),
      .prev_prio_i (prev_prio),
      .prev_tag_i  (prev_tag),
      .next_prio_i (next_prio),
      .next_tag_i  (next_tag),
      .new_prio_i  (new_prio),
      .new_tag_i   (new_tag),
      .gt_o        (gt[k]),
      .prio_o      (prio_q[k]),
      .tag_o       (tag_q[k]),
      .prio_next_o (prio_nx[k]),
      .tag_next_o  (tag_nx[k])
    );
  end

  // result fields taken from the head cell's next value
  assign empty_d  = (count_d == '0);
  assign full_d   = (CMPW'(count_d) >= cap_eff);
  assign top_ext  = XW'($signed(prio_nx[0]));
  assign top_prio = empty_d ? '1 : top_ext[PRIO_W-1:0];
  assign top_tag  = empty_d ? '0 : tag_nx[0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= {full_d, empty_d, COUNT_W'(count_d), top_tag, top_prio, ok};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

[design/spq_checker.sv]
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_unit

module spq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [spq_pkg::OUT_W-1:0] m_axis_tdata
);
  import spq_pkg::*;

  // a waiting result item holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // every accepted item yields a result item on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after accepted item");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[38] == (m_axis_tdata[37:33] == '0)))
    else $error("empty flag disagrees with count");

  // an empty queue reports the sentinel top entry
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[38] |->
      (m_axis_tdata[16:1] == 16'hFFFF) && (m_axis_tdata[32:17] == '0))
    else $error("empty queue reports a top entry");

  // capacity is at least one, so empty and full never coincide
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[38] && m_axis_tdata[39]))
    else $error("queue reported empty and full");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
